// ===== sv/cbd_pkg.sv =====
// Shared types, codes and address decode for the CPU bus decoder.
package cbd_pkg;

  localparam int RAM_DEPTH_DEF = 2048;

  localparam logic [1:0] OP_READ   = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_UPDATE = 2'd2;

  localparam logic [2:0] REG_UNUSED = 3'd0;
  localparam logic [2:0] REG_RAM    = 3'd1;
  localparam logic [2:0] REG_PPU    = 3'd2;
  localparam logic [2:0] REG_DMA    = 3'd3;
  localparam logic [2:0] REG_JOY    = 3'd4;
  localparam logic [2:0] REG_APU    = 3'd5;
  localparam logic [2:0] REG_CART   = 3'd6;

  localparam logic [15:0] ADDR_PPU    = 16'h2000;
  localparam logic [15:0] ADDR_APU    = 16'h4000;
  localparam logic [15:0] ADDR_DMA    = 16'h4014;
  localparam logic [15:0] ADDR_JOY1   = 16'h4016;
  localparam logic [15:0] ADDR_JOY2   = 16'h4017;
  localparam logic [15:0] ADDR_UNUSED = 16'h4018;
  localparam logic [15:0] ADDR_CART   = 16'h6000;

  localparam logic [7:0] JOY_OPEN_BUS = 8'h40;
  localparam logic [7:0] JOY_FILL     = 8'h80;

  typedef struct packed {
    logic       update;
    logic       strobe_wr;
    logic       read;
    logic       port;
    logic       strobe_data;
    logic [7:0] pad1;
    logic [7:0] pad2;
  } pad_req_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [2:0]  region;
    logic        forward_valid;
    logic        forward_write;
    logic [15:0] forward_address;
    logic [7:0]  forward_data;
    logic        ram_read;
  } result_t;

  function automatic logic [2:0] decode_region(input logic [15:0] a);
    logic [2:0] r;
    if (a < ADDR_PPU)                        r = REG_RAM;
    else if (a < ADDR_APU)                   r = REG_PPU;
    else if (a == ADDR_DMA)                  r = REG_DMA;
    else if (a == ADDR_JOY1 || a == ADDR_JOY2) r = REG_JOY;
    else if (a < ADDR_UNUSED)                r = REG_APU;
    else if (a < ADDR_CART)                  r = REG_UNUSED;
    else                                     r = REG_CART;
    return r;
  endfunction

endpackage

// ===== sv/cbd_if.sv =====
// Request and result channel interfaces.
interface cbd_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [15:0] address;
  logic [7:0]  write_data;
  logic [7:0]  pad1_buttons;
  logic [7:0]  pad2_buttons;

  modport source (output valid, operation, address, write_data, pad1_buttons, pad2_buttons,
                  input ready);
  modport sink   (input valid, operation, address, write_data, pad1_buttons, pad2_buttons,
                  output ready);
endinterface

interface cbd_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic [2:0]  region;
  logic        forward_valid;
  logic        forward_write;
  logic [15:0] forward_address;
  logic [7:0]  forward_data;

  modport source (output valid, read_data, region, forward_valid, forward_write,
                  forward_address, forward_data, input ready);
  modport sink   (input valid, read_data, region, forward_valid, forward_write,
                  forward_address, forward_data, output ready);
endinterface

// ===== sv/cbd_joypad.sv =====
// Two controller ports: button latches, shift registers and strobe.
module cbd_joypad (
  input  logic              clk,
  input  logic              rst,
  input  cbd_pkg::pad_req_t pad_req,
  output logic              read_bit
);
  import cbd_pkg::*;

  logic [7:0] pad_latch [2];
  logic [7:0] pad_shift [2];
  logic       strobe_bit;

  assign read_bit = pad_shift[pad_req.port][0];

  always_ff @(posedge clk) begin
    if (rst) begin
      pad_latch[0] <= '0;
      pad_latch[1] <= '0;
      pad_shift[0] <= '0;
      pad_shift[1] <= '0;
      strobe_bit   <= 1'b0;
    end else begin
      if (pad_req.update) begin
        pad_latch[0] <= pad_req.pad1;
        pad_latch[1] <= pad_req.pad2;
      end
      if (pad_req.strobe_wr) begin
        if (strobe_bit || pad_req.strobe_data) begin
          pad_shift[0] <= pad_latch[0];
          pad_shift[1] <= pad_latch[1];
        end
        strobe_bit <= pad_req.strobe_data;
      end
      if (pad_req.read && !strobe_bit) begin
        pad_shift[pad_req.port] <= JOY_FILL | (pad_shift[pad_req.port] >> 1);
      end
    end
  end

endmodule

// ===== sv/cpu_bus_decode_ram_joypad.sv =====
// CPU bus decoder with mirrored work RAM, controller ports and forwarding.
//
//   channel  dir  handshake            payload
//   req      in   req.valid/req.ready  operation, address, write_data, pad buttons
//   rsp      out  rsp.valid/rsp.ready  read_data, region, forward_* fields
//
// One request per cycle unless the output stalls; each result passes s1, then o.
// Work RAM is one synchronous memory read and written at request acceptance.
// A read stage and an output register part the two sides, so a
// request is taken while an earlier result waits. Synchronous reset clears
// the controller state and the pipeline; RAM content is undefined until written.
module cpu_bus_decode_ram_joypad #(
  parameter int RAM_DEPTH = cbd_pkg::RAM_DEPTH_DEF
) (
  input logic       clk,
  input logic       rst,
  cbd_req_if.sink   req,
  cbd_rsp_if.source rsp
);
  import cbd_pkg::*;

  localparam int AW = $clog2(RAM_DEPTH);

  logic [7:0]    work_ram [RAM_DEPTH];
  logic [7:0]    ram_q;
  logic [AW-1:0] ram_idx;
  logic          accept;
  logic          is_rd;
  logic          is_wr;
  logic [2:0]    region;
  logic          ram_we;
  logic          ram_re;
  logic          read_bit;
  pad_req_t      pad_req;
  result_t       res_next;
  result_t       s1;
  result_t       s1_out;
  result_t       o;
  logic          s1_valid;
  logic          o_valid;
  logic          s1_move;

  assign is_rd   = req.operation == OP_READ;
  assign is_wr   = req.operation == OP_WRITE;
  assign region  = (is_rd || is_wr) ? decode_region(req.address) : REG_UNUSED;
  assign ram_idx = req.address[AW-1:0];

  assign s1_move   = s1_valid && (!o_valid || rsp.ready);
  assign req.ready = !rst && (!s1_valid || s1_move);
  assign accept    = req.valid && req.ready;

  assign ram_we = accept && is_wr && region == REG_RAM;
  assign ram_re = accept && is_rd && region == REG_RAM;

  always_comb begin
    pad_req.update      = accept && req.operation == OP_UPDATE;
    pad_req.strobe_wr   = accept && is_wr && req.address == ADDR_JOY1;
    pad_req.read        = accept && is_rd && region == REG_JOY;
    pad_req.port        = req.address[0];
    pad_req.strobe_data = req.write_data[0];
    pad_req.pad1        = req.pad1_buttons;
    pad_req.pad2        = req.pad2_buttons;
  end

  cbd_joypad u_joypad (
    .clk      (clk),
    .rst      (rst),
    .pad_req  (pad_req),
    .read_bit (read_bit)
  );

  always_comb begin
    res_next                 = '0;
    res_next.region          = region;
    res_next.ram_read        = is_rd && region == REG_RAM;
    if (is_rd || is_wr) begin
      unique case (region)
        REG_PPU, REG_CART: begin
          res_next.forward_valid   = 1'b1;
          res_next.forward_address = req.address;
          if (is_wr) begin
            res_next.forward_write = 1'b1;
            res_next.forward_data  = req.write_data;
          end
        end
        REG_DMA, REG_APU: begin
          if (is_wr) begin
            res_next.forward_valid   = 1'b1;
            res_next.forward_write   = 1'b1;
            res_next.forward_address = req.address;
            res_next.forward_data    = req.write_data;
          end
        end
        REG_JOY: begin
          if (is_rd) begin
            res_next.read_data = JOY_OPEN_BUS | {7'd0, read_bit};
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      work_ram[ram_idx] <= req.write_data;
    end
    if (ram_re) begin
      ram_q <= work_ram[ram_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        o_valid <= 1'b1;
      end else if (rsp.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    s1_out = s1;
    if (s1.ram_read) begin
      s1_out.read_data = ram_q;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= res_next;
    end
    if (s1_move) begin
      o <= s1_out;
    end
  end

  assign rsp.valid           = o_valid;
  assign rsp.read_data       = o.read_data;
  assign rsp.region          = o.region;
  assign rsp.forward_valid   = o.forward_valid;
  assign rsp.forward_write   = o.forward_write;
  assign rsp.forward_address = o.forward_address;
  assign rsp.forward_data    = o.forward_data;

endmodule

// ===== tb/cpu_bus_decode_ram_joypad_test.sv =====
// Self-checking testbench for the CPU bus decoder with work RAM and controller ports.
module cpu_bus_decode_ram_joypad_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cbd_pkg::*;

  localparam int RAM_WORDS = RAM_DEPTH_DEF;
  localparam int REQ_TOTAL = 1475;
  localparam int TAIL = 150;
  localparam int HOLD_CYCLES = 250;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [1:0] OP_UNDEF = 2'd3;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [7:0]  pad1_buttons;
    logic [7:0]  pad2_buttons;
  } bus_req_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [2:0]  region;
    logic        forward_valid;
    logic        forward_write;
    logic [15:0] forward_address;
    logic [7:0]  forward_data;
  } bus_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cbd_req_if req ();
  cbd_rsp_if rsp ();

  cpu_bus_decode_ram_joypad uut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  bus_req_t pending_reqs[$];
  bus_rsp_t results_due[$];
  bus_req_t cur_req;

  logic [7:0] ram_image [RAM_WORDS];
  logic [7:0] btn_latch [2];
  logic [7:0] btn_shift [2];
  logic       strobe_q;

  bit ram_written [RAM_WORDS];
  int written_idx[$];

  int n_accepted = 0;
  int n_checked = 0;
  int n_errors = 0;
  int n_ram_reads = 0;
  int n_pad_reads = 0;
  int n_forwards = 0;
  int cycles = 0;
  int src_gap = 0;
  int sink_gap = 0;
  logic hold_rsp = 1'b0;

  function automatic bus_rsp_t bus_access(bus_req_t r);
    bus_rsp_t o;
    logic wr;
    logic port;
    int idx;
    o = '0;
    if (r.operation == OP_UPDATE) begin
      btn_latch[0] = r.pad1_buttons;
      btn_latch[1] = r.pad2_buttons;
    end else if (r.operation == OP_READ || r.operation == OP_WRITE) begin
      wr = (r.operation == OP_WRITE);
      if (r.address[15:13] == 3'b000) o.region = REG_RAM;
      else if (r.address[15:13] == 3'b001) o.region = REG_PPU;
      else if (r.address >= ADDR_CART) o.region = REG_CART;
      else if (r.address >= ADDR_UNUSED) o.region = REG_UNUSED;
      else if (r.address == ADDR_DMA) o.region = REG_DMA;
      else if (r.address == ADDR_JOY1 || r.address == ADDR_JOY2) o.region = REG_JOY;
      else o.region = REG_APU;
      case (o.region)
        REG_RAM: begin
          idx = r.address % RAM_WORDS;
          if (wr) begin
            ram_image[idx] = r.write_data;
          end else begin
            o.read_data = ram_image[idx];
            n_ram_reads++;
          end
        end
        REG_PPU, REG_CART: begin
          o.forward_valid = 1'b1;
          o.forward_address = r.address;
          if (wr) begin
            o.forward_write = 1'b1;
            o.forward_data = r.write_data;
          end
        end
        REG_DMA, REG_APU: begin
          if (wr) begin
            o.forward_valid = 1'b1;
            o.forward_write = 1'b1;
            o.forward_address = r.address;
            o.forward_data = r.write_data;
          end
        end
        REG_JOY: begin
          if (wr) begin
            if (r.address == ADDR_JOY1) begin
              if (strobe_q || r.write_data[0]) begin
                btn_shift[0] = btn_latch[0];
                btn_shift[1] = btn_latch[1];
              end
              strobe_q = r.write_data[0];
            end
          end else begin
            port = r.address[0];
            o.read_data = {7'd0, btn_shift[port][0]} | JOY_OPEN_BUS;
            if (!strobe_q) btn_shift[port] = (btn_shift[port] >> 1) | JOY_FILL;
            n_pad_reads++;
          end
        end
        default: ;
      endcase
      if (o.forward_valid) n_forwards++;
    end
    return o;
  endfunction

  task automatic add_req(input logic [1:0] op, input logic [15:0] addr,
                         input logic [7:0] wd, input logic [7:0] p1, input logic [7:0] p2);
    bus_req_t r;
    int idx;
    r.operation = op;
    r.address = addr;
    r.write_data = wd;
    r.pad1_buttons = p1;
    r.pad2_buttons = p2;
    if (op == OP_WRITE && addr < ADDR_PPU) begin
      idx = addr % RAM_WORDS;
      if (!ram_written[idx]) begin
        ram_written[idx] = 1'b1;
        written_idx.push_back(idx);
      end
    end
    pending_reqs.push_back(r);
  endtask

  task automatic add_bus(input logic [1:0] op, input logic [15:0] addr, input logic [7:0] wd);
    add_req(op, addr, wd, 8'($urandom), 8'($urandom));
  endtask

  task automatic add_ram_read();
    int idx;
    idx = written_idx[$urandom_range(0, written_idx.size() - 1)];
    add_bus(OP_READ, 16'(idx + RAM_WORDS * $urandom_range(0, 8192 / RAM_WORDS - 1)),
            8'($urandom));
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else begin
      if (req.valid && req.ready) begin
        results_due.push_back(bus_access(cur_req));
        n_accepted++;
      end
      if (!req.valid || req.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          req.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          cur_req = pending_reqs.pop_front();
          req.valid <= 1'b1;
          req.operation <= cur_req.operation;
          req.address <= cur_req.address;
          req.write_data <= cur_req.write_data;
          req.pad1_buttons <= cur_req.pad1_buttons;
          req.pad2_buttons <= cur_req.pad2_buttons;
          if (pending_reqs.size() > TAIL && $urandom_range(0, 11) == 0)
            src_gap = $urandom_range(1, 19);
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    bus_rsp_t got;
    bus_rsp_t want;
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        got.read_data = rsp.read_data;
        got.region = rsp.region;
        got.forward_valid = rsp.forward_valid;
        got.forward_write = rsp.forward_write;
        got.forward_address = rsp.forward_address;
        got.forward_data = rsp.forward_data;
        if (results_due.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("unexpected result %h", got);
        end else begin
          want = results_due.pop_front();
          n_checked++;
          if (got.read_data !== want.read_data || got.region !== want.region ||
              got.forward_valid !== want.forward_valid ||
              got.forward_write !== want.forward_write ||
              got.forward_address !== want.forward_address ||
              got.forward_data !== want.forward_data) begin
            n_errors++;
            if (n_errors <= 10) begin
              $display("result %0d: expected rd=%h rg=%0d fv=%b fw=%b fa=%h fd=%h",
                       n_checked, want.read_data, want.region, want.forward_valid,
                       want.forward_write, want.forward_address, want.forward_data);
              $display("result %0d: got      rd=%h rg=%0d fv=%b fw=%b fa=%h fd=%h",
                       n_checked, got.read_data, got.region, got.forward_valid,
                       got.forward_write, got.forward_address, got.forward_data);
            end
          end
        end
      end
      if (hold_rsp) begin
        rsp.ready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
        if (pending_reqs.size() > TAIL && $urandom_range(0, 11) == 0)
          sink_gap = $urandom_range(1, 19);
      end
    end
  end

  initial begin
    while (rst || n_accepted < 300) @(posedge clk);
    hold_rsp <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rsp <= 1'b0;
  end

  initial begin
    int pick;
    int reads;
    btn_latch[0] = '0;
    btn_latch[1] = '0;
    btn_shift[0] = '0;
    btn_shift[1] = '0;
    strobe_q = 1'b0;
    foreach (ram_written[i]) ram_written[i] = 1'b0;

    add_bus(OP_WRITE, 16'h0000, 8'h00);
    add_bus(OP_WRITE, 16'h07FF, 8'hFF);
    add_bus(OP_READ, 16'h0800, 8'hFF);
    add_bus(OP_READ, 16'h1FFF, 8'h00);
    add_bus(OP_READ, ADDR_PPU, 8'h00);
    add_bus(OP_WRITE, 16'h3FFF, 8'hA5);
    add_bus(OP_WRITE, ADDR_DMA, 8'h02);
    add_bus(OP_READ, ADDR_DMA, 8'h00);
    add_bus(OP_WRITE, ADDR_APU, 8'h5A);
    add_bus(OP_READ, 16'h4015, 8'h00);
    add_bus(OP_READ, ADDR_UNUSED, 8'h00);
    add_bus(OP_WRITE, 16'h5FFF, 8'h3C);
    add_bus(OP_READ, ADDR_CART, 8'h00);
    add_bus(OP_WRITE, 16'hFFFF, 8'hC3);
    add_bus(OP_READ, ADDR_JOY1, 8'h00);
    add_req(OP_UPDATE, 16'h0000, 8'h00, 8'hFF, 8'h00);
    add_bus(OP_WRITE, ADDR_JOY1, 8'h01);
    add_bus(OP_READ, ADDR_JOY1, 8'h00);
    add_bus(OP_READ, ADDR_JOY2, 8'h00);
    add_bus(OP_WRITE, ADDR_JOY1, 8'hFE);
    add_bus(OP_READ, ADDR_JOY1, 8'h00);
    add_bus(OP_READ, ADDR_JOY2, 8'h00);
    add_bus(OP_WRITE, ADDR_JOY2, 8'h01);
    add_req(OP_UNDEF, 16'h4016, 8'h01, 8'hFF, 8'hFF);

    while (pending_reqs.size() < REQ_TOTAL) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        if (written_idx.size() == 0 || $urandom_range(0, 1) == 0)
          add_bus(OP_WRITE, 16'($urandom_range(0, 16'h1FFF)), 8'($urandom));
        else
          add_ram_read();
      end else if (pick < 60) begin
        add_req(OP_UPDATE, 16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        add_bus(OP_WRITE, ADDR_JOY1, 8'($urandom) | 8'h01);
        repeat ($urandom_range(0, 2)) add_bus(OP_READ, ADDR_JOY1 | 16'($urandom_range(0, 1)),
                                              8'($urandom));
        add_bus(OP_WRITE, ADDR_JOY1, 8'($urandom) & 8'hFE);
        reads = $urandom_range(1, 10);
        repeat (reads) begin
          if ($urandom_range(0, 15) == 0) add_bus(OP_WRITE, ADDR_JOY2, 8'($urandom));
          add_bus(OP_READ, ADDR_JOY1 | 16'($urandom_range(0, 1)), 8'($urandom));
        end
      end else if (pick < 70) begin
        case ($urandom_range(0, 2))
          0: add_bus(OP_READ, ADDR_JOY1 | 16'($urandom_range(0, 1)), 8'($urandom));
          1: add_bus(OP_WRITE, ADDR_JOY1, 8'($urandom));
          default: add_bus(OP_WRITE, ADDR_JOY2, 8'($urandom));
        endcase
      end else if (pick < 95) begin
        case ($urandom_range(0, 4))
          0: add_bus(2'($urandom_range(0, 1)), 16'($urandom_range(16'h2000, 16'h3FFF)),
                     8'($urandom));
          1: add_bus(2'($urandom_range(0, 1)), 16'($urandom_range(16'h4000, 16'h4017)),
                     8'($urandom));
          2: add_bus(2'($urandom_range(0, 1)), ADDR_DMA, 8'($urandom));
          3: add_bus(2'($urandom_range(0, 1)), 16'($urandom_range(16'h4018, 16'h5FFF)),
                     8'($urandom));
          default: add_bus(2'($urandom_range(0, 1)), 16'($urandom_range(16'h6000, 16'hFFFF)),
                           8'($urandom));
        endcase
      end else begin
        add_req(OP_UNDEF, 16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      end
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || req.valid) @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    n_errors += results_due.size();

    $display("%0d requests accepted, %0d results checked, %0d mismatches",
             n_accepted, n_checked, n_errors);
    $display("covered %0d work RAM reads, %0d controller port reads, %0d forwarded accesses",
             n_ram_reads, n_pad_reads, n_forwards);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
